// ===== rtl/core/dbam_pkg.sv =====
// shared types and constants for the debounced button arm and mode menu
`timescale 1ns / 1ps

package dbam_pkg;

  localparam int unsigned NumButtons = 4;
  localparam int unsigned DebounceW  = 16;

  localparam logic [DebounceW-1:0] DebounceReset = 16'd35;

  // button lane order, also the bit order of the press flags
  localparam int unsigned BtnUp    = 0;
  localparam int unsigned BtnDown  = 1;
  localparam int unsigned BtnEnter = 2;
  localparam int unsigned BtnBack  = 3;

  typedef enum logic [1:0] {
    SCR_STATUS = 2'd0,
    SCR_MAIN   = 2'd1,
    SCR_ARM    = 2'd2,
    SCR_MODE   = 2'd3
  } screen_e;

  typedef enum logic [1:0] {
    DRV_RADIO  = 2'd0,
    DRV_STICK  = 2'd1,
    DRV_TILT   = 2'd2,
    DRV_SPEECH = 2'd3
  } drive_mode_e;

  localparam logic MainCurArm    = 1'b0;
  localparam logic ArmChoiceArm  = 1'b0;
  localparam logic ArmChoiceOff  = 1'b1;

  typedef logic [NumButtons-1:0] press_t;

  typedef struct packed {
    screen_e     screen;
    logic        main_cursor;
    logic        arm_choice;
    drive_mode_e mode_choice;
    logic        armed;
    drive_mode_e drive_mode;
    logic        stop;
  } menu_view_t;

endpackage

// ===== rtl/core/dbam_lane.sv =====
// one debounce lane: stable level, edge time and press detection for one button
`timescale 1ns / 1ps

module dbam_lane #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           raw_i,
  input  logic [TIME_BITS-1:0]           now_i,
  input  logic [dbam_pkg::DebounceW-1:0] debounce_ms_i,
  output logic                           press_o
);
  import dbam_pkg::*;

  localparam int unsigned CmpW = (TIME_BITS > DebounceW) ? TIME_BITS : DebounceW;

  logic                 stable_q, stable_d;
  logic [TIME_BITS-1:0] edge_q, edge_d;
  logic [TIME_BITS-1:0] elapsed;
  logic                 settled;

  // modulo 2^TIME_BITS distance since the last agreeing sample
  assign elapsed = now_i - edge_q;
  assign settled = CmpW'(elapsed) >= CmpW'(debounce_ms_i);

  always_comb begin
    stable_d = stable_q;
    edge_d   = edge_q;
    press_o  = 1'b0;
    if (raw_i != stable_q) begin
      if (settled) begin
        stable_d = raw_i;
        edge_d   = now_i;
        press_o  = stable_q & ~raw_i;
      end
    end else begin
      edge_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b1;
      edge_q   <= '0;
    end else if (step_i) begin
      stable_q <= stable_d;
      edge_q   <= edge_d;
    end
  end

endmodule

// ===== rtl/core/dbam_menu.sv =====
// merging stage: menu screen state machine driven by the lanes' presses
`timescale 1ns / 1ps

module dbam_menu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  dbam_pkg::press_t     press_i,
  output dbam_pkg::menu_view_t view_o
);
  import dbam_pkg::*;

  screen_e     screen_q, screen_d;
  logic        main_cur_q, main_cur_d;
  logic        arm_choice_q, arm_choice_d;
  drive_mode_e mode_choice_q, mode_choice_d;
  logic        armed_q, armed_d;
  drive_mode_e drive_mode_q, drive_mode_d;
  logic        stop;

  logic        up, down, enter, back;
  logic        main_cur_mv;
  logic        arm_choice_mv;
  logic [1:0]  mode_choice_mv;

  assign up    = press_i[BtnUp];
  assign down  = press_i[BtnDown];
  assign enter = press_i[BtnEnter];
  assign back  = press_i[BtnBack];

  // cursors after up and down, before enter is looked at
  assign main_cur_mv    = main_cur_q ^ up ^ down;
  assign arm_choice_mv  = arm_choice_q ^ (up | down);
  assign mode_choice_mv = 2'(mode_choice_q) - {1'b0, up} + {1'b0, down};

  // next screen
  always_comb begin
    screen_d = screen_q;
    case (screen_q)
      SCR_STATUS: begin
        if (enter) screen_d = SCR_MAIN;
      end
      SCR_MAIN: begin
        if (back) begin
          screen_d = SCR_STATUS;
        end else if (enter) begin
          screen_d = (main_cur_mv == MainCurArm) ? SCR_ARM : SCR_MODE;
        end
      end
      SCR_ARM, SCR_MODE: begin
        if (back) begin
          screen_d = SCR_MAIN;
        end else if (enter) begin
          screen_d = SCR_STATUS;
        end
      end
      default: screen_d = SCR_STATUS;
    endcase
  end

  // cursors, arm flag, drive mode and stop
  always_comb begin
    main_cur_d    = main_cur_q;
    arm_choice_d  = arm_choice_q;
    mode_choice_d = mode_choice_q;
    armed_d       = armed_q;
    drive_mode_d  = drive_mode_q;
    stop          = 1'b0;
    case (screen_q)
      SCR_STATUS: begin
        if (enter) main_cur_d = MainCurArm;
      end
      SCR_MAIN: begin
        if (!back) begin
          main_cur_d = main_cur_mv;
          if (enter) begin
            if (main_cur_mv == MainCurArm) begin
              arm_choice_d = armed_q ? ArmChoiceArm : ArmChoiceOff;
            end else begin
              mode_choice_d = drive_mode_q;
            end
          end
        end
      end
      SCR_ARM: begin
        if (!back) begin
          arm_choice_d = arm_choice_mv;
          if (enter) begin
            armed_d = (arm_choice_mv == ArmChoiceArm);
            stop    = 1'b1;
          end
        end
      end
      SCR_MODE: begin
        if (!back) begin
          mode_choice_d = drive_mode_e'(mode_choice_mv);
          if (enter) begin
            drive_mode_d = drive_mode_e'(mode_choice_mv);
            stop         = 1'b1;
          end
        end
      end
      default: stop = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_q      <= SCR_STATUS;
      main_cur_q    <= MainCurArm;
      arm_choice_q  <= ArmChoiceOff;
      mode_choice_q <= DRV_STICK;
      armed_q       <= 1'b0;
      drive_mode_q  <= DRV_STICK;
    end else if (step_i) begin
      screen_q      <= screen_d;
      main_cur_q    <= main_cur_d;
      arm_choice_q  <= arm_choice_d;
      mode_choice_q <= mode_choice_d;
      armed_q       <= armed_d;
      drive_mode_q  <= drive_mode_d;
    end
  end

  assign view_o = '{
    screen:      screen_d,
    main_cursor: main_cur_d,
    arm_choice:  arm_choice_d,
    mode_choice: mode_choice_d,
    armed:       armed_d,
    drive_mode:  drive_mode_d,
    stop:        stop
  };

endmodule

// ===== rtl/core/debounced_button_arm_mode_menu.sv =====
// Debounced four-button menu controller with arm and drive mode selection.
// Input channel (in_valid_i / in_stall_o): one poll tick per item, with four
// raw active-low button levels and the millisecond time of the poll.
// Output channel (out_valid_o / out_stall_i): one result item per tick with
// the screen, cursors, armed flag, drive mode, stop pulse and press flags.
// Four debounce lanes work on the buttons of a tick side by side; the menu
// state machine merges their presses in the same cycle.
// The result is registered and is valid the cycle after the tick is accepted.
// Throughput: one tick per cycle while the held result is not stalled.
// An output register holds the result; a new tick is taken whenever that
// register is empty or being read in the same cycle, so a stalled receiver
// holds the result steady and stalls the sender only while it stalls.
// cfg_we_i writes debounce_ms from the 16-bit cfg_wdata_i; write only while
// no tick is in flight.
// Reset: debounce_ms 35, all buttons released with edge time 0, status
// screen, disarmed, joystick mode, output register empty.
`timescale 1ns / 1ps

module debounced_button_arm_mode_menu #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        raw_up_i,
  input  logic        raw_down_i,
  input  logic        raw_enter_i,
  input  logic        raw_back_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  cur_screen_o,
  output logic        cur_main_cursor_o,
  output logic        cur_arm_choice_o,
  output logic [1:0]  cur_mode_choice_o,
  output logic        is_armed_o,
  output logic [1:0]  selected_mode_o,
  output logic        stop_pulse_o,
  output logic [3:0]  press_flags_o
);
  import dbam_pkg::*;

  logic [DebounceW-1:0] debounce_q;
  logic [TIME_BITS-1:0] now_t;
  logic [NumButtons-1:0] raw;
  press_t               press;
  menu_view_t           view;
  logic                 step;
  logic                 out_valid_q;
  menu_view_t           view_q;
  press_t               press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceReset;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = out_valid_q & out_stall_i;
  assign step       = in_valid_i & ~in_stall_o;
  assign now_t      = TIME_BITS'(now_ms_i);

  assign raw[BtnUp]    = raw_up_i;
  assign raw[BtnDown]  = raw_down_i;
  assign raw[BtnEnter] = raw_enter_i;
  assign raw[BtnBack]  = raw_back_i;

  for (genvar g = 0; g < NumButtons; g++) begin : g_lane
    dbam_lane #(
      .TIME_BITS(TIME_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (step),
      .raw_i        (raw[g]),
      .now_i        (now_t),
      .debounce_ms_i(debounce_q),
      .press_o      (press[g])
    );
  end

  dbam_menu u_menu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .press_i(press),
    .view_o (view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      view_q  <= view;
      press_q <= press;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cur_screen_o      = view_q.screen;
  assign cur_main_cursor_o = view_q.main_cursor;
  assign cur_arm_choice_o  = view_q.arm_choice;
  assign cur_mode_choice_o = view_q.mode_choice;
  assign is_armed_o        = view_q.armed;
  assign selected_mode_o   = view_q.drive_mode;
  assign stop_pulse_o      = view_q.stop;
  assign press_flags_o     = press_q;

endmodule

// ===== rtl/core/dbam_checker.sv =====
// port-level checks for the debounced button menu, bound to the top level
`timescale 1ns / 1ps

module dbam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  cur_screen_o,
  input logic        stop_pulse_o,
  input logic [3:0]  press_flags_o
);
  import dbam_pkg::*;

  // a stop is only issued by an enter press that confirms a choice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_pulse_o |-> press_flags_o[BtnEnter])
    else $error("stop pulse without enter press");

  // confirming arm or mode always returns to the status screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_pulse_o |-> cur_screen_o == SCR_STATUS)
    else $error("stop pulse outside status screen");

  // the input side only stalls while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no held result");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cur_screen_o)
      && $stable(press_flags_o) && $stable(stop_pulse_o))
    else $error("stalled result changed");

endmodule

bind debounced_button_arm_mode_menu dbam_checker u_dbam_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cur_screen_o (cur_screen_o),
  .stop_pulse_o (stop_pulse_o),
  .press_flags_o(press_flags_o)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the debounced button arm and mode menu
`timescale 1ns / 1ps

module testbench;
  import dbam_pkg::*;

  typedef struct packed {
    menu_view_t view;
    press_t     presses;
  } menu_result_t;

  typedef struct packed {
    logic         write_cfg;
    logic [15:0]  cfg_value;
    press_t       held;
    logic [31:0]  stamp;
    logic         typed;
    menu_result_t want;
  } plan_row_t;

  localparam press_t HoldNone  = '0;
  localparam press_t HoldUp    = press_t'(1 << BtnUp);
  localparam press_t HoldDown  = press_t'(1 << BtnDown);
  localparam press_t HoldEnter = press_t'(1 << BtnEnter);
  localparam press_t HoldBack  = press_t'(1 << BtnBack);

  localparam menu_result_t ResetMenu = '{
    view: '{screen: SCR_STATUS, main_cursor: MainCurArm, arm_choice: ArmChoiceOff,
            mode_choice: DRV_STICK, armed: 1'b0, drive_mode: DRV_STICK,
            stop: 1'b0},
    presses: HoldNone};
  localparam menu_result_t OpenedMenu = '{
    view: '{screen: SCR_MAIN, main_cursor: MainCurArm, arm_choice: ArmChoiceOff,
            mode_choice: DRV_STICK, armed: 1'b0, drive_mode: DRV_STICK,
            stop: 1'b0},
    presses: HoldEnter};

  localparam int PlanLen    = 23;
  localparam int QuietLimit = 1000;

  // held buttons per row; the first rows run at the reset debounce time
  localparam plan_row_t Plan [PlanLen] = '{
    '{1'b0, 16'd0, HoldNone,                     32'd0,          1'b1, ResetMenu},
    '{1'b0, 16'd0, HoldEnter,                    32'd10,         1'b1, ResetMenu},
    '{1'b0, 16'd0, HoldEnter,                    32'd45,         1'b1, OpenedMenu},
    '{1'b0, 16'd0, HoldNone,                     32'd50,         1'b0, '0},
    '{1'b0, 16'd0, HoldNone,                     32'd80,         1'b0, '0},
    '{1'b1, 16'd0, HoldNone,                     32'd0,          1'b0, '0},
    '{1'b0, 16'd0, HoldUp,                       32'hFFFF_FFFD,  1'b0, '0},
    '{1'b0, 16'd0, HoldDown | HoldEnter | HoldBack, 32'hFFFF_FFFE, 1'b0, '0},
    '{1'b0, 16'd0, HoldUp,                       32'hFFFF_FFFF,  1'b0, '0},
    '{1'b0, 16'd0, HoldEnter,                    32'd0,          1'b0, '0},
    '{1'b0, 16'd0, HoldUp | HoldDown,            32'd1,          1'b0, '0},
    '{1'b0, 16'd0, HoldEnter,                    32'd2,          1'b0, '0},
    '{1'b0, 16'd0, HoldUp | HoldDown,            32'd3,          1'b0, '0},
    '{1'b0, 16'd0, HoldEnter,                    32'd4,          1'b0, '0},
    '{1'b0, 16'd0, HoldBack,                     32'd5,          1'b0, '0},
    '{1'b0, 16'd0, HoldEnter,                    32'd6,          1'b0, '0},
    '{1'b0, 16'd0, HoldDown,                     32'd7,          1'b0, '0},
    '{1'b0, 16'd0, HoldEnter,                    32'd8,          1'b0, '0},
    '{1'b0, 16'd0, HoldUp,                       32'd9,          1'b0, '0},
    '{1'b0, 16'd0, HoldNone,                     32'd10,         1'b0, '0},
    '{1'b0, 16'd0, HoldUp,                       32'd11,         1'b0, '0},
    '{1'b0, 16'd0, HoldDown,                     32'd12,         1'b0, '0},
    '{1'b0, 16'd0, HoldUp | HoldEnter,           32'd13,         1'b0, '0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        raw_up_i    = 1'b1;
  logic        raw_down_i  = 1'b1;
  logic        raw_enter_i = 1'b1;
  logic        raw_back_i  = 1'b1;
  logic [31:0] now_ms_i    = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  cur_screen_o;
  logic        cur_main_cursor_o;
  logic        cur_arm_choice_o;
  logic [1:0]  cur_mode_choice_o;
  logic        is_armed_o;
  logic [1:0]  selected_mode_o;
  logic        stop_pulse_o;
  logic [3:0]  press_flags_o;

  // predictor state
  logic [15:0]  debounce_q = DebounceReset;
  logic [3:0]   stable_q   = '1;
  logic [31:0]  edge_ms_q [NumButtons] = '{default: '0};
  screen_e      screen_q   = SCR_STATUS;
  logic         main_cur_q = MainCurArm;
  logic         arm_cur_q  = ArmChoiceOff;
  drive_mode_e  mode_cur_q = DRV_STICK;
  logic         armed_q    = 1'b0;
  drive_mode_e  drive_q    = DRV_STICK;

  menu_result_t expected_menu [$];
  menu_result_t head_menu;
  int           mismatches   = 0;
  int           quiet_cycles = 0;
  int           ticks_sent   = 0;
  logic         no_idle      = 1'b0;
  logic [31:0]  tick_ms      = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  debounced_button_arm_mode_menu u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_up_i         (raw_up_i),
    .raw_down_i       (raw_down_i),
    .raw_enter_i      (raw_enter_i),
    .raw_back_i       (raw_back_i),
    .now_ms_i         (now_ms_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cur_screen_o     (cur_screen_o),
    .cur_main_cursor_o(cur_main_cursor_o),
    .cur_arm_choice_o (cur_arm_choice_o),
    .cur_mode_choice_o(cur_mode_choice_o),
    .is_armed_o       (is_armed_o),
    .selected_mode_o  (selected_mode_o),
    .stop_pulse_o     (stop_pulse_o),
    .press_flags_o    (press_flags_o)
  );

  // debounce all four lanes, then apply the presses to the menu
  function automatic menu_result_t predict_menu(input press_t raw, input logic [31:0] stamp);
    menu_result_t res;
    press_t       presses;
    logic [31:0]  elapsed;
    logic         stop;
    int           b;
    presses = '0;
    stop    = 1'b0;
    for (b = 0; b < NumButtons; b++) begin
      if (raw[b] != stable_q[b]) begin
        elapsed = stamp - edge_ms_q[b];
        if (elapsed >= {16'b0, debounce_q}) begin
          presses[b]   = stable_q[b] & ~raw[b];
          stable_q[b]  = raw[b];
          edge_ms_q[b] = stamp;
        end
      end else begin
        edge_ms_q[b] = stamp;
      end
    end
    case (screen_q)
      SCR_STATUS: begin
        if (presses[BtnEnter]) begin
          screen_q   = SCR_MAIN;
          main_cur_q = MainCurArm;
        end
      end
      SCR_MAIN: begin
        if (presses[BtnBack]) begin
          screen_q = SCR_STATUS;
        end else begin
          main_cur_q = main_cur_q ^ presses[BtnUp] ^ presses[BtnDown];
          if (presses[BtnEnter]) begin
            if (main_cur_q == MainCurArm) begin
              screen_q  = SCR_ARM;
              arm_cur_q = armed_q ? ArmChoiceArm : ArmChoiceOff;
            end else begin
              screen_q   = SCR_MODE;
              mode_cur_q = drive_q;
            end
          end
        end
      end
      SCR_ARM: begin
        if (presses[BtnBack]) begin
          screen_q = SCR_MAIN;
        end else begin
          if (presses[BtnUp] || presses[BtnDown]) arm_cur_q = ~arm_cur_q;
          if (presses[BtnEnter]) begin
            armed_q  = (arm_cur_q == ArmChoiceArm);
            stop     = 1'b1;
            screen_q = SCR_STATUS;
          end
        end
      end
      default: begin
        if (presses[BtnBack]) begin
          screen_q = SCR_MAIN;
        end else begin
          if (presses[BtnUp]) mode_cur_q = drive_mode_e'(mode_cur_q + 2'd3);
          if (presses[BtnDown]) mode_cur_q = drive_mode_e'(mode_cur_q + 2'd1);
          if (presses[BtnEnter]) begin
            drive_q  = mode_cur_q;
            stop     = 1'b1;
            screen_q = SCR_STATUS;
          end
        end
      end
    endcase
    res.view.screen      = screen_q;
    res.view.main_cursor = main_cur_q;
    res.view.arm_choice  = arm_cur_q;
    res.view.mode_choice = mode_cur_q;
    res.view.armed       = armed_q;
    res.view.drive_mode  = drive_q;
    res.view.stop        = stop;
    res.presses          = presses;
    return res;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // result checking and the quiet-cycle count for the watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_menu.size() == 0) begin
        $display("%0t: result item with nothing expected, screen %0d press %0h",
                 $time, cur_screen_o, press_flags_o);
        mismatches++;
      end else begin
        head_menu = expected_menu.pop_front();
        check_field("screen", head_menu.view.screen, cur_screen_o);
        check_field("main cursor", head_menu.view.main_cursor, cur_main_cursor_o);
        check_field("arm choice", head_menu.view.arm_choice, cur_arm_choice_o);
        check_field("mode choice", head_menu.view.mode_choice, cur_mode_choice_o);
        check_field("armed", head_menu.view.armed, is_armed_o);
        check_field("drive mode", head_menu.view.drive_mode, selected_mode_o);
        check_field("stop pulse", head_menu.view.stop, stop_pulse_o);
        check_field("press flags", head_menu.presses, press_flags_o);
      end
    end
  end

  task automatic send_tick(input press_t held, input logic [31:0] stamp,
                           input logic typed, input menu_result_t typed_menu);
    menu_result_t predicted;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    raw_up_i    <= ~held[BtnUp];
    raw_down_i  <= ~held[BtnDown];
    raw_enter_i <= ~held[BtnEnter];
    raw_back_i  <= ~held[BtnBack];
    now_ms_i    <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_menu(~held, stamp);
    expected_menu.push_back(typed ? typed_menu : predicted);
    ticks_sent++;
  endtask

  task automatic step_and_send(input press_t held, input int unsigned max_step);
    tick_ms = tick_ms + $urandom_range(0, max_step);
    send_tick(held, tick_ms, 1'b0, '0);
  endtask

  // the register is written only once every tick has its result back
  task automatic set_debounce(input logic [15:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_menu.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    debounce_q = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic press_t pick_buttons();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return HoldEnter;
    if (pick < 55) return HoldUp;
    if (pick < 75) return HoldDown;
    if (pick < 88) return HoldBack;
    return press_t'($urandom_range(1, 15));
  endfunction

  // mostly clean press and release gestures, some with bounce, some raw noise
  task automatic random_phase(input logic [15:0] db, input int n_ticks);
    int unsigned span;
    int unsigned kind;
    int          stop_at;
    press_t      mask;
    set_debounce(db);
    span    = db * 2 / 3 + 1;
    tick_ms = $urandom();
    stop_at = ticks_sent + n_ticks;
    while (ticks_sent < stop_at) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) tick_ms = $urandom();
          step_and_send(press_t'($urandom_range(0, 15)), span);
        end
      end else begin
        mask = pick_buttons();
        if (kind < 4) begin
          repeat ($urandom_range(1, 4)) begin
            step_and_send(mask, span / 8);
            step_and_send(HoldNone, span / 8);
          end
        end
        repeat ($urandom_range(1, 8)) step_and_send(mask, span);
        repeat ($urandom_range(1, 8)) step_and_send(HoldNone, span);
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 9)) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12)) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("** debounced_button_arm_mode_menu: FAILED **");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].write_cfg) set_debounce(Plan[i].cfg_value);
      else send_tick(Plan[i].held, Plan[i].stamp, Plan[i].typed, Plan[i].want);
    end

    random_phase(16'd0, 200);
    random_phase(16'd1, 150);
    random_phase(DebounceReset, 200);
    random_phase(16'hFFFF, 150);
    random_phase(16'($urandom_range(2, 300)), 200);
    random_phase(16'($urandom_range(0, 65535)), 150);
    no_idle = 1'b1;
    random_phase(DebounceReset, 250);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_menu.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** debounced_button_arm_mode_menu: PASSED **");
    end else begin
      $display("** debounced_button_arm_mode_menu: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dbam_pkg.sv
rtl/core/dbam_lane.sv
rtl/core/dbam_menu.sv
rtl/core/debounced_button_arm_mode_menu.sv
rtl/core/dbam_checker.sv
tb/testbench.sv
